>>> hw/rtl/tlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlp_pkg - shared types and constants for the turtle line plotter
// Command record passed from the front end to the back end, op codes,
// default sizes and the quarter-wave sine table (Q1.15).
// ----------------------------------------------------------------------------
package tlp_pkg;

  // Input op codes
  localparam logic [1:0] OP_PLACE   = 2'd0;
  localparam logic [1:0] OP_FORWARD = 2'd1;
  localparam logic [1:0] OP_TURN    = 2'd2;

  localparam int DEF_SCREEN_COLS = 120;
  localparam int DEF_SCREEN_ROWS = 80;
  localparam int DEF_MAX_STEPS   = 63;

  localparam int QUEUE_DEPTH = 4;

  localparam int STEP_W = 6;   // step count 1..63
  localparam int DIV_W  = 24;  // |trig * length| >> 7 fits in 24 bits

  typedef enum logic [1:0] {
    CMD_PLACE,
    CMD_FORWARD,
    CMD_TURN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [8:0]         heading;  // already reduced to 0..359
    logic [15:0]        length;
    logic [STEP_W-1:0]  steps;
    logic signed [9:0]  turn;
  } cmd_t;

  localparam logic [15:0] QUARTER_SINE [0:90] = '{
        16'd0,   16'd572,  16'd1144,  16'd1715,  16'd2286,
     16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
     16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
     16'd8481,  16'd9032,  16'd9580, 16'd10126, 16'd10668,
    16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
    16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
    16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
    16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
    16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
    16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
    16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
    16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
    16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
    16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
    16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
    16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
    16'd32767
  };

  // Sine of a heading in 0..359 degrees, Q1.15
  function automatic logic signed [15:0] sine_deg(input logic [8:0] d);
    logic [8:0] idx;
    logic       neg;
    begin
      if (d <= 9'd90) begin
        idx = d;
        neg = 1'b0;
      end else if (d <= 9'd180) begin
        idx = 9'd180 - d;
        neg = 1'b0;
      end else if (d <= 9'd270) begin
        idx = d - 9'd180;
        neg = 1'b1;
      end else begin
        idx = 9'd360 - d;
        neg = 1'b1;
      end
      sine_deg = neg ? -$signed(QUARTER_SINE[idx[6:0]])
                     : $signed(QUARTER_SINE[idx[6:0]]);
    end
  endfunction

endpackage

>>> hw/rtl/turtle_line_plotter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turtle_line_plotter - turtle-graphics line plotter
// Place, turn and forward commands drive a Q16.16 turtle; each forward move
// is split into steps and every step boundary is sent out as a screen point.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tuser op, tdata command fields
//  m_axis    out  m_axis_tvalid/tready      tdata point, tuser on_screen,
//                                           tlast final point of a move
//
//  Place and turn are done in the executor's idle state; unused op codes are
//  dropped in the input stage. A forward move of n steps runs through lookup,
//  multiply, a one-bit-per-cycle divide by the step count, sign fix-up, then
//  n + 1 points at one per cycle while the output is not stalled.
//  A four-entry command queue sits between the input stage and the executor,
//  so input transfers keep being taken while points are sent out, until it fills.
//  Synchronous active-high reset puts the turtle at the origin facing zero
//  degrees and empties the queue. A stalled output holds the executor only.
//
module turtle_line_plotter #(
  parameter int SCREEN_COLS = tlp_pkg::DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = tlp_pkg::DEF_SCREEN_ROWS,
  parameter int MAX_STEPS   = tlp_pkg::DEF_MAX_STEPS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata, low bit up: place_x[31:0], place_y[63:32], place_heading[72:64],
  //   move_length[88:73], turn_degrees[98:89], zero pad[103:99]
  input  logic [103:0]  s_axis_tdata,
  // tuser: op[1:0]
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tdata, low bit up: column[15:0], row[30:16], zero pad[31]
  output logic [31:0]   m_axis_tdata,
  // tuser: on_screen
  output logic          m_axis_tuser,
  output logic          m_axis_tlast
);

  logic               fe_valid;
  logic               fe_ready;
  tlp_pkg::cmd_t      fe_cmd;
  logic               q_valid;
  logic               q_ready;
  tlp_pkg::cmd_t      q_cmd;
  logic signed [15:0] column;
  logic signed [14:0] row;

  // input stage: decode and step count
  tlp_front #(
    .MAX_STEPS (MAX_STEPS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .op            (s_axis_tuser),
    .place_x       ($signed(s_axis_tdata[31:0])),
    .place_y       ($signed(s_axis_tdata[63:32])),
    .place_heading (s_axis_tdata[72:64]),
    .move_length   (s_axis_tdata[88:73]),
    .turn_degrees  ($signed(s_axis_tdata[98:89])),
    .cmd_valid     (fe_valid),
    .cmd_ready     (fe_ready),
    .cmd           (fe_cmd)
  );

  // decouples input stage from the executor
  tlp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .wr_cmd   (fe_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  // executor: turtle state, divide, point generation
  tlp_back #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .column    (column),
    .row       (row),
    .on_screen (m_axis_tuser),
    .last      (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, row, column};

`ifndef SYNTHESIS
  // a decoded command waiting on a full queue must not vanish
  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    fe_valid && !fe_ready |=> fe_valid)
    else $error("front command dropped while queue full");

  // a forward move takes the executor out of its idle state
  a_forward_busy: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready && (q_cmd.kind == tlp_pkg::CMD_FORWARD) |=> !q_ready)
    else $error("executor still idle after taking a forward move");

  // reset leaves no point pending
  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");
`endif

endmodule

>>> hw/rtl/tlp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlp_front - input stage
// Takes input transfers, drops unused op codes, reduces the place heading,
// works out the step count of a forward move and holds one command.
// ----------------------------------------------------------------------------
module tlp_front #(
  parameter int MAX_STEPS = tlp_pkg::DEF_MAX_STEPS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          op,
  input  logic signed [31:0]  place_x,
  input  logic signed [31:0]  place_y,
  input  logic [8:0]          place_heading,
  input  logic [15:0]         move_length,
  input  logic signed [9:0]   turn_degrees,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output tlp_pkg::cmd_t       cmd
);

  localparam logic [8:0] STEP_LIM = 9'(MAX_STEPS);

  tlp_pkg::cmd_t cmd_next;
  logic          op_known;
  logic [8:0]    raw_steps;

  assign in_ready = !cmd_valid || cmd_ready;

  always_comb begin
    cmd_next         = '0;
    op_known         = 1'b1;
    raw_steps        = move_length[15:7];
    cmd_next.x       = place_x;
    cmd_next.y       = place_y;
    cmd_next.length  = move_length;
    cmd_next.turn    = turn_degrees;
    cmd_next.heading = (place_heading >= 9'd360) ? place_heading - 9'd360 : place_heading;
    if (raw_steps == 9'd0) begin
      cmd_next.steps = tlp_pkg::STEP_W'(1);
    end else if (raw_steps > STEP_LIM) begin
      cmd_next.steps = STEP_LIM[tlp_pkg::STEP_W-1:0];
    end else begin
      cmd_next.steps = raw_steps[tlp_pkg::STEP_W-1:0];
    end
    case (op)
      tlp_pkg::OP_PLACE:   cmd_next.kind = tlp_pkg::CMD_PLACE;
      tlp_pkg::OP_FORWARD: cmd_next.kind = tlp_pkg::CMD_FORWARD;
      tlp_pkg::OP_TURN:    cmd_next.kind = tlp_pkg::CMD_TURN;
      default: begin
        cmd_next.kind = tlp_pkg::CMD_PLACE;
        op_known      = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      // unused op code: transfer taken, nothing forwarded
      cmd_valid <= in_valid && op_known;
    end
    if (in_ready && in_valid) begin
      cmd <= cmd_next;
    end
  end

endmodule

>>> hw/rtl/tlp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlp_queue - command queue
// Small FIFO of decoded commands between front and back end.
// ----------------------------------------------------------------------------
module tlp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  tlp_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  logic          rd_ready,
  output tlp_pkg::cmd_t rd_cmd
);

  localparam int PTR_W = $clog2(tlp_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(tlp_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(tlp_pkg::QUEUE_DEPTH);

  tlp_pkg::cmd_t     slots [tlp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign wr_ready = (count != FULL);
  assign rd_valid = (count != '0);
  assign rd_cmd   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

endmodule

>>> hw/rtl/tlp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlp_back - command executor
// Holds position and heading, runs place and turn, and for a forward move
// looks up sine/cosine, multiplies, divides by the step count bit-serially
// and emits the points through an output register.
// ----------------------------------------------------------------------------
module tlp_back #(
  parameter int SCREEN_COLS = tlp_pkg::DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = tlp_pkg::DEF_SCREEN_ROWS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  tlp_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] column,
  output logic signed [14:0] row,
  output logic               on_screen,
  output logic               last
);

  localparam int SW = tlp_pkg::STEP_W;
  localparam int DW = tlp_pkg::DIV_W;
  localparam int BC_W = $clog2(DW);
  localparam logic [15:0] COLS_LIM = 16'(SCREEN_COLS);
  localparam logic [14:0] ROWS_LIM = 15'(SCREEN_ROWS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t             state;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [8:0]         heading;
  logic signed [15:0] trig_c;
  logic signed [15:0] trig_s;
  logic [15:0]        len;
  logic [SW-1:0]      steps;
  logic               neg_x;
  logic               neg_y;
  logic [DW-1:0]      divd_x;
  logic [DW-1:0]      divd_y;
  logic [SW-1:0]      rem_x;
  logic [SW-1:0]      rem_y;
  logic [BC_W-1:0]    bit_cnt;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic [SW-1:0]      pt_cnt;

  // combinational helpers
  logic [8:0]         cos_deg;
  logic signed [32:0] prod_x;
  logic signed [32:0] prod_y;
  logic [32:0]        mag_x;
  logic [32:0]        mag_y;
  logic [SW:0]        sh_x;
  logic [SW:0]        sh_y;
  logic               ge_x;
  logic               ge_y;
  logic signed [10:0] turn_sum;
  logic [8:0]         turn_head;
  logic signed [15:0] col_pt;
  logic signed [15:0] ry_pt;
  logic signed [15:0] row_half;
  logic               load;

  function automatic logic signed [15:0] round_unit(input logic signed [31:0] p);
    logic [31:0] mag;
    logic [32:0] sum;
    logic [16:0] r;
    begin
      mag = p[31] ? (~p + 32'd1) : p;
      sum = {1'b0, mag} + 33'h8000;
      r   = sum[32:16];
      if (!p[31]) begin
        round_unit = (r > 17'd32767) ? 16'sh7FFF : $signed(r[15:0]);
      end else begin
        round_unit = $signed(r[15:0] ^ 16'hFFFF) + 16'sd1;  // r <= 32768
      end
    end
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] s;
    begin
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
        sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        sat_add = s[31:0];
      end
    end
  endfunction

  assign cmd_ready = (state == ST_IDLE);
  assign load      = !out_valid || out_ready;

  always_comb begin
    cos_deg   = (heading >= 9'd270) ? heading - 9'd270 : heading + 9'd90;
    prod_x    = trig_c * $signed({1'b0, len});
    prod_y    = trig_s * $signed({1'b0, len});
    mag_x     = prod_x[32] ? 33'(-prod_x) : prod_x;
    mag_y     = prod_y[32] ? 33'(-prod_y) : prod_y;
    sh_x      = {rem_x, divd_x[DW-1]};
    sh_y      = {rem_y, divd_y[DW-1]};
    ge_x      = (sh_x >= {1'b0, steps});
    ge_y      = (sh_y >= {1'b0, steps});
    // sum spans -512..870, so up to two wraps either way
    turn_sum  = $signed({2'b00, heading}) + 11'(cmd.turn);
    if (turn_sum < -11'sd360) begin
      turn_sum = turn_sum + 11'sd720;
    end else if (turn_sum < 0) begin
      turn_sum = turn_sum + 11'sd360;
    end else if (turn_sum >= 11'sd720) begin
      turn_sum = turn_sum - 11'sd720;
    end else if (turn_sum >= 11'sd360) begin
      turn_sum = turn_sum - 11'sd360;
    end
    turn_head = turn_sum[8:0];
    col_pt    = round_unit(pos_x);
    ry_pt     = round_unit(pos_y);
    row_half  = (ry_pt + $signed({15'd0, ry_pt[15]})) >>> 1;  // toward zero
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos_x     <= '0;
      pos_y     <= '0;
      heading   <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_EMIT) && load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd.kind)
              tlp_pkg::CMD_PLACE: begin
                pos_x   <= cmd.x;
                pos_y   <= cmd.y;
                heading <= cmd.heading;
              end
              tlp_pkg::CMD_TURN: begin
                heading <= turn_head;
              end
              tlp_pkg::CMD_FORWARD: begin
                trig_c <= tlp_pkg::sine_deg(cos_deg);
                trig_s <= tlp_pkg::sine_deg(heading);
                len    <= cmd.length;
                steps  <= cmd.steps;
                state  <= ST_MUL;
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          // dividing by 128 first, then by steps, truncates the same way
          neg_x   <= prod_x[32];
          neg_y   <= prod_y[32];
          divd_x  <= mag_x[DW+6:7];
          divd_y  <= mag_y[DW+6:7];
          rem_x   <= '0;
          rem_y   <= '0;
          bit_cnt <= BC_W'(DW - 1);
          state   <= ST_DIV;
        end
        ST_DIV: begin
          rem_x   <= ge_x ? SW'(sh_x - {1'b0, steps}) : sh_x[SW-1:0];
          rem_y   <= ge_y ? SW'(sh_y - {1'b0, steps}) : sh_y[SW-1:0];
          divd_x  <= {divd_x[DW-2:0], ge_x};
          divd_y  <= {divd_y[DW-2:0], ge_y};
          bit_cnt <= bit_cnt - BC_W'(1);
          if (bit_cnt == '0) begin
            state <= ST_SIGN;
          end
        end
        ST_SIGN: begin
          dx     <= neg_x ? -$signed(32'(divd_x)) : $signed(32'(divd_x));
          dy     <= neg_y ? -$signed(32'(divd_y)) : $signed(32'(divd_y));
          pt_cnt <= '0;
          state  <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load) begin
            column    <= col_pt;
            row       <= row_half[14:0];
            on_screen <= !col_pt[15] && ($unsigned(col_pt) < COLS_LIM) &&
                         !row_half[15] && ($unsigned(row_half[14:0]) < ROWS_LIM);
            last      <= (pt_cnt == steps);
            if (pt_cnt == steps) begin
              state <= ST_IDLE;
            end else begin
              pos_x  <= sat_add(pos_x, dx);
              pos_y  <= sat_add(pos_y, dy);
              pt_cnt <= pt_cnt + SW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> tb/sv/tb_turtle_line_plotter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_turtle_line_plotter - self-checking bench for the turtle line plotter
// A short table of place, turn and forward commands probes screen edges,
// saturation and heading wrap, then weighted random commands follow. Every
// point transfer is checked against a behavioural turtle model kept here.
// ----------------------------------------------------------------------------
module tb_turtle_line_plotter;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         N_RANDOM  = 320;
  localparam int         N_PLAN    = 24;

  // Screen size as built into the instance below
  localparam int COLS = tlp_pkg::DEF_SCREEN_COLS;
  localparam int ROWS = tlp_pkg::DEF_SCREEN_ROWS;

  // One plotted point as it leaves the block
  typedef struct packed {
    logic [15:0] col;
    logic [14:0] row;
    logic        vis;
    logic        fin;
  } point_t;

  // Directed row: command fields, then the first point where it is obvious
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] x;
    logic [31:0] y;
    logic [8:0]  hdg;
    logic [15:0] len;
    logic [9:0]  turn;
    logic        known;
    logic [15:0] col;
    logic [14:0] row;
    logic        vis;
  } plan_row_t;

  localparam plan_row_t PLAN [N_PLAN] = '{
    // straight out of reset: origin, facing zero, zero length
    '{tlp_pkg::OP_FORWARD,
      32'h0, 32'h0, 9'd0, 16'h0000, 10'd0, 1'b1, 16'd0, 15'd0, 1'b1},
    // bottom-right visible corner, then a one-step move
    '{tlp_pkg::OP_PLACE,
      32'h0077_0000, 32'h009F_0000, 9'd0, 16'h0, 10'd0, 1'b0, 16'd0, 15'd0, 1'b0},
    '{tlp_pkg::OP_FORWARD,
      32'h0, 32'h0, 9'd0, 16'h0080, 10'd0, 1'b1, 16'd119, 15'd79, 1'b1},
    // half unit rounds away from zero; y of -1 halves to row 0, still on screen
    '{tlp_pkg::OP_PLACE,
      32'h0000_8000, 32'hFFFF_0000, 9'd90, 16'h0, 10'd0, 1'b0, 16'd0, 15'd0, 1'b0},
    '{tlp_pkg::OP_FORWARD,
      32'h0, 32'h0, 9'd0, 16'h007F, 10'd0, 1'b1, 16'd1, 15'd0, 1'b1},
    // positive saturation
    '{tlp_pkg::OP_PLACE,
      32'h7FFF_FFFF, 32'h7FFF_FFFF, 9'd45, 16'h0, 10'd0, 1'b0, 16'd0, 15'd0, 1'b0},
    '{tlp_pkg::OP_FORWARD,
      32'h0, 32'h0, 9'd0, 16'hFFFF, 10'd0, 1'b1, 16'h7FFF, 15'h3FFF, 1'b0},
    // negative saturation
    '{tlp_pkg::OP_PLACE,
      32'h8000_0000, 32'h8000_0000, 9'd225, 16'h0, 10'd0, 1'b0, 16'd0, 15'd0, 1'b0},
    '{tlp_pkg::OP_FORWARD,
      32'h0, 32'h0, 9'd0, 16'hFFFF, 10'd0, 1'b1, 16'h8000, 15'h4000, 1'b0},
    // heading beyond 359 wraps
    '{tlp_pkg::OP_PLACE,
      32'h003C_0000, 32'h0050_0000, 9'd511, 16'h0, 10'd0, 1'b0, 16'd0, 15'd0, 1'b0},
    '{tlp_pkg::OP_FORWARD,
      32'h0, 32'h0, 9'd0, 16'h0100, 10'd0, 1'b0, 16'd0, 15'd0, 1'b0},
    // full turns both ways, then the extremes of the turn field
    '{tlp_pkg::OP_TURN,
      32'h0, 32'h0, 9'd0, 16'h0, 10'h168, 1'b0, 16'd0, 15'd0, 1'b0},
    '{tlp_pkg::OP_TURN,
      32'h0, 32'h0, 9'd0, 16'h0, 10'h298, 1'b0, 16'd0, 15'd0, 1'b0},
    '{tlp_pkg::OP_TURN,
      32'h0, 32'h0, 9'd0, 16'h0, 10'h1FF, 1'b0, 16'd0, 15'd0, 1'b0},
    '{tlp_pkg::OP_FORWARD,
      32'h0, 32'h0, 9'd0, 16'h0280, 10'd0, 1'b0, 16'd0, 15'd0, 1'b0},
    '{tlp_pkg::OP_TURN,
      32'h0, 32'h0, 9'd0, 16'h0, 10'h200, 1'b0, 16'd0, 15'd0, 1'b0},
    // unused op code with every payload bit set: must leave no trace
    '{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'h1FF, 16'hFFFF, 10'h3FF,
      1'b0, 16'd0, 15'd0, 1'b0},
    // longest move
    '{tlp_pkg::OP_FORWARD,
      32'h0, 32'h0, 9'd0, 16'h1F80, 10'd0, 1'b0, 16'd0, 15'd0, 1'b0},
    // first column past the right edge
    '{tlp_pkg::OP_PLACE,
      32'h0078_0000, 32'h0, 9'd180, 16'h0, 10'd0, 1'b0, 16'd0, 15'd0, 1'b0},
    '{tlp_pkg::OP_FORWARD,
      32'h0, 32'h0, 9'd0, 16'h0500, 10'd0, 1'b1, 16'd120, 15'd0, 1'b0},
    // column -1 and first row past the bottom edge
    '{tlp_pkg::OP_PLACE,
      32'hFFFF_8000, 32'h00A0_0000, 9'd270, 16'h0, 10'd0, 1'b0, 16'd0, 15'd0, 1'b0},
    '{tlp_pkg::OP_FORWARD,
      32'h0, 32'h0, 9'd0, 16'h0300, 10'd0, 1'b1, 16'hFFFF, 15'd80, 1'b0},
    '{tlp_pkg::OP_TURN,
      32'h0, 32'h0, 9'd0, 16'h0, 10'h001, 1'b0, 16'd0, 15'd0, 1'b0},
    '{tlp_pkg::OP_FORWARD,
      32'h0, 32'h0, 9'd0, 16'h0A00, 10'd0, 1'b0, 16'd0, 15'd0, 1'b0}
  };

  logic         clk = 1'b0;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;   // place_x, place_y, place_heading, move_length,
                                // turn_degrees, zero pad (low bit up)
  logic [1:0]   s_axis_tuser;   // op
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;   // column, row, zero pad (low bit up)
  logic         m_axis_tuser;   // on_screen
  logic         m_axis_tlast;

  // Turtle state mirrored on the bench side
  longint pen_x;
  longint pen_y;
  int     turtle_hdg;

  point_t pending_points[$];   // points owed by the block, oldest first
  int     n_fail;
  int     n_cmds;
  int     n_moves;
  int     points_seen;
  bit     stall_en;            // random idling on both sides

  turtle_line_plotter i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  task automatic flag_error(input string msg);
    n_fail++;
    if (n_fail <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  // Q1.15 sine of any whole-degree angle, from the quarter-wave table
  function automatic int trig_q15(input int deg);
    int d;
    d = ((deg % 360) + 360) % 360;
    if (d <= 90) begin
      return int'(tlp_pkg::QUARTER_SINE[d]);
    end else if (d <= 180) begin
      return int'(tlp_pkg::QUARTER_SINE[180 - d]);
    end else if (d <= 270) begin
      return -int'(tlp_pkg::QUARTER_SINE[d - 180]);
    end
    return -int'(tlp_pkg::QUARTER_SINE[360 - d]);
  endfunction

  // Q16.16 to whole units, half away from zero, clipped to 16 bits
  function automatic int to_unit(input longint p);
    longint r;
    if (p >= 0) begin
      r = (p + 64'sd32768) >>> 16;
    end else begin
      r = -((-p + 64'sd32768) >>> 16);
    end
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return int'(r);
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Step the turtle along a line and queue every point it should plot
  task automatic trace_line(input logic [15:0] len);
    int     steps;
    longint dx;
    longint dy;
    int     col;
    int     rw;
    point_t p;
    steps = int'(len >> 7);
    if (steps < 1) steps = 1;
    if (steps > tlp_pkg::DEF_MAX_STEPS) steps = tlp_pkg::DEF_MAX_STEPS;
    dx = (longint'(trig_q15(turtle_hdg + 90)) * longint'(len)) / longint'(steps * 128);
    dy = (longint'(trig_q15(turtle_hdg)) * longint'(len)) / longint'(steps * 128);
    for (int i = 0; i <= steps; i++) begin
      col   = to_unit(pen_x);
      rw    = to_unit(pen_y) / 2;   // truncates toward zero
      p.col = col[15:0];
      p.row = rw[14:0];
      p.vis = (col >= 0 && col < COLS && rw >= 0 && rw < ROWS);
      p.fin = (i == steps);
      pending_points.push_back(p);
      if (i < steps) begin
        pen_x = clip32(pen_x + dx);
        pen_y = clip32(pen_y + dy);
      end
    end
  endtask

  task automatic apply_cmd(input logic [1:0] op, input logic [103:0] pl);
    case (op)
      tlp_pkg::OP_PLACE: begin
        pen_x      = longint'($signed(pl[31:0]));
        pen_y      = longint'($signed(pl[63:32]));
        turtle_hdg = int'(pl[72:64]) % 360;
      end
      tlp_pkg::OP_TURN: begin
        turtle_hdg = (((turtle_hdg + int'($signed(pl[98:89]))) % 360) + 360) % 360;
      end
      tlp_pkg::OP_FORWARD: begin
        n_moves++;
        trace_line(pl[88:73]);
      end
      default: ;   // unused op code is dropped
    endcase
  endtask

  // Offer one command, wait for its transfer, then update the model.
  // The model is touched on the falling edge so it never races the checker.
  task automatic send_cmd(input logic [1:0] op, input logic [103:0] pl,
                          output int first_idx);
    while (stall_en && $urandom_range(0, 99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= pl;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    first_idx = pending_points.size();
    n_cmds++;
    apply_cmd(op, pl);
  endtask

  // Output back-pressure
  always @(negedge clk) begin
    m_axis_tready <= (rst || !stall_en) ? 1'b1 : ($urandom_range(0, 99) >= 9);
  end

  // Point checker
  always @(posedge clk) begin : watch_points
    point_t got;
    point_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[15:0], m_axis_tdata[30:16], m_axis_tuser, m_axis_tlast};
      points_seen++;
      if (pending_points.size() == 0) begin
        flag_error($sformatf("unexpected point col %0d row %0d vis %0b last %0b",
                             $signed(got.col), $signed(got.row), got.vis, got.fin));
      end else begin
        want = pending_points.pop_front();
        if (got.col !== want.col || got.row !== want.row ||
            got.vis !== want.vis || got.fin !== want.fin) begin
          flag_error($sformatf(
            "point %0d: exp col %0d row %0d vis %0b last %0b, got col %0d row %0d vis %0b last %0b",
            points_seen, $signed(want.col), $signed(want.row), want.vis, want.fin,
            $signed(got.col), $signed(got.row), got.vis, got.fin));
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t   r;
    point_t      p;
    int          base;
    int          pick;
    int          ux;
    int          uy;
    logic [1:0]  op;
    logic [31:0] x;
    logic [31:0] y;
    logic [8:0]  hdg;
    logic [15:0] len;
    logic [9:0]  turn;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = tlp_pkg::OP_PLACE;
    stall_en      = 1'b1;
    n_fail        = 0;
    n_cmds        = 0;
    n_moves       = 0;
    points_seen   = 0;
    pen_x         = 0;
    pen_y         = 0;
    turtle_hdg    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table; typed first points override the model's where given
    for (int i = 0; i < N_PLAN; i++) begin
      r = PLAN[i];
      send_cmd(r.op, {5'd0, r.turn, r.len, r.hdg, r.y, r.x}, base);
      if (r.known) begin
        p     = pending_points[base];
        p.col = r.col;
        p.row = r.row;
        p.vis = r.vis;
        pending_points[base] = p;
      end
    end

    // Random commands, mostly near the screen, with a quiet stretch
    for (int k = 0; k < N_RANDOM; k++) begin
      stall_en = !(k >= 140 && k < 200);
      x    = $urandom;
      y    = $urandom;
      hdg  = 9'($urandom_range(0, 511));
      len  = 16'($urandom_range(0, 65535));
      turn = 10'($urandom_range(0, 1023));
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        op = tlp_pkg::OP_PLACE;
        if ($urandom_range(0, 7) != 0) begin
          ux  = int'($urandom_range(0, 160)) - 20;
          uy  = int'($urandom_range(0, 190)) - 10;
          x   = {ux[15:0], 16'($urandom)};
          y   = {uy[15:0], 16'($urandom)};
          hdg = 9'($urandom_range(0, 359));
        end
      end else if (pick < 42) begin
        op = tlp_pkg::OP_TURN;
        if ($urandom_range(0, 3) != 0) begin
          ux   = int'($urandom_range(0, 720)) - 360;
          turn = ux[9:0];
        end
      end else if (pick < 95) begin
        op   = tlp_pkg::OP_FORWARD;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          len = 16'($urandom_range(0, 1023));
        end else if (pick < 9) begin
          len = 16'($urandom_range(1024, 8191));
        end
      end else begin
        op = OP_UNUSED;
      end
      send_cmd(op, {5'd0, turn, len, hdg, y, x}, base);
    end
    s_axis_tvalid <= 1'b0;
    stall_en = 1'b1;

    // Drain, then watch a while for stray points
    while (pending_points.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Run: %0d commands accepted, %0d of them forward moves", n_cmds, n_moves);
    $display("Run: %0d points compared, %0d failures", points_seen, n_fail);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: 5 ms, far beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("Timeout waiting for transfers");
    $display("Some tests failed");
    $finish;
  end

endmodule
